// File: rtl/lbvs_pkg.sv
package lbvs_pkg;

    localparam int SLOTS     = 10;
    localparam int Q_W       = 32;   // saturated Q1.30 component, +1.0 included
    localparam int D_W       = 33;   // pos - pivot
    localparam int R_W       = 38;   // cross / rotate partial sums
    localparam int B_W       = 36;   // multiplier second operand
    localparam int PROD_W    = Q_W + B_W;
    localparam int P_W       = 40;   // moved point
    localparam int WP_W      = P_W + 18;
    localparam int WT_W      = 25;
    localparam int N_OPS     = 15;

    localparam logic [3:0]      SLOT_LAST = 4'd9;
    localparam logic [WT_W-1:0] WT_MAX    = {WT_W{1'b1}};

    localparam logic [1:0] GRP_C = 2'd0;  // c = u x d
    localparam logic [1:0] GRP_E = 2'd1;  // e = u x c
    localparam logic [1:0] GRP_G = 2'd2;  // g = w * c

    localparam logic CMD_WRITE     = 1'b0;
    localparam logic CMD_INFLUENCE = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [7:0]        bone;
        logic [3:0]        slot;
        logic signed [31:0] word_value;
        logic [16:0]       weight;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic              last_influence;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] land_x;
        logic signed [31:0] land_y;
        logic signed [31:0] land_z;
        logic               held;
    } t_out_item;

    // One rounded product step: target += / -= u[ai] * b[bi]; b 0..2 is d, 3..5 is c.
    typedef struct packed {
        logic [1:0] grp;
        logic [1:0] tidx;
        logic       neg;
        logic [1:0] ai;
        logic [2:0] bi;
    } t_op;

    function automatic t_op op_entry(input logic [4:0] i);
        t_op o;
        case (i)
            5'd0:    o = '{GRP_C, 2'd0, 1'b0, 2'd1, 3'd2};
            5'd1:    o = '{GRP_C, 2'd0, 1'b1, 2'd2, 3'd1};
            5'd2:    o = '{GRP_C, 2'd1, 1'b0, 2'd2, 3'd0};
            5'd3:    o = '{GRP_C, 2'd1, 1'b1, 2'd0, 3'd2};
            5'd4:    o = '{GRP_C, 2'd2, 1'b0, 2'd0, 3'd1};
            5'd5:    o = '{GRP_C, 2'd2, 1'b1, 2'd1, 3'd0};
            5'd6:    o = '{GRP_E, 2'd0, 1'b0, 2'd1, 3'd5};
            5'd7:    o = '{GRP_E, 2'd0, 1'b1, 2'd2, 3'd4};
            5'd8:    o = '{GRP_E, 2'd1, 1'b0, 2'd2, 3'd3};
            5'd9:    o = '{GRP_E, 2'd1, 1'b1, 2'd0, 3'd5};
            5'd10:   o = '{GRP_E, 2'd2, 1'b0, 2'd0, 3'd4};
            5'd11:   o = '{GRP_E, 2'd2, 1'b1, 2'd1, 3'd3};
            5'd12:   o = '{GRP_G, 2'd0, 1'b0, 2'd3, 3'd3};
            5'd13:   o = '{GRP_G, 2'd1, 1'b0, 2'd3, 3'd4};
            5'd14:   o = '{GRP_G, 2'd2, 1'b0, 2'd3, 3'd5};
            default: o = '{GRP_C, 2'd0, 1'b0, 2'd0, 3'd0};
        endcase
        return o;
    endfunction

endpackage

// File: rtl/lbvs_bone_mem.sv
module lbvs_bone_mem #(
    parameter int DEPTH = 640,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [31:0]   i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [31:0]   o_rd_data
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/lbvs_div.sv
// Restoring divider, one quotient bit per cycle.
module lbvs_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [24:0] i_den,
    output logic        o_busy,
    output logic        o_done,
    output logic [63:0] o_quo
);

    logic [25:0] r_rem;
    logic [63:0] r_quo;
    logic [24:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [25:0] rem_sh;
    logic        fits;

    assign rem_sh = {r_rem[24:0], r_quo[63]};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? (rem_sh - {1'b0, r_den}) : rem_sh;
            r_quo <= {r_quo[62:0], fits};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// File: rtl/linear_blend_vertex_skinning.sv
// Linear blend skinning of one vertex position. Table-write transfers (cmd 0) load one
// 32-bit word of a bone entry into the bone memory (BONES x 10 words); writes with
// bone >= BONES or slot > 9 are dropped. Influence transfers (cmd 1) read the ten words
// of the bone through the single memory read port, then run 15 rounded Q1.30 products
// through one shared 32x36 multiplier, each in a multiply (S_MUL) and an accumulate
// (S_ACC) step, form the moved point (S_PSUM) and add it, weighted, into the 64-bit
// saturating sums (S_WMUL and S_SACC per axis); a skipped influence (bad bone or zero
// weight) adds nothing. The last influence then divides the three sums by the weight
// total with a one-bit-per-cycle divider and presents one result in the output register;
// held = 0 with zero coordinates when no weight counted.
// One item is processed at a time; the input is stalled while an item is in work, but a
// finished result may sit in the output register while the next item is taken.
module linear_blend_vertex_skinning #(
    parameter int BONES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lbvs_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lbvs_pkg::t_out_item o_out_data
);

    localparam int DEPTH = BONES * lbvs_pkg::SLOTS;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_ACC   = 4'd3;
    localparam logic [3:0] S_PSUM  = 4'd4;
    localparam logic [3:0] S_WMUL  = 4'd5;
    localparam logic [3:0] S_SACC  = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_DWAIT = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;

    localparam logic signed [lbvs_pkg::Q_W-1:0] Q_POS = 32'sh4000_0000;
    localparam logic signed [lbvs_pkg::Q_W-1:0] Q_NEG = -32'sh4000_0000;

    logic [3:0] r_state;
    logic [4:0] r_cnt;

    // latched influence
    logic [AW-1:0]  r_base;
    logic [16:0]    r_weight;
    logic           r_last;
    logic signed [31:0] r_pos [3];

    // bone-derived operands and partial results
    logic signed [lbvs_pkg::Q_W-1:0]    r_u [4];
    logic signed [lbvs_pkg::D_W-1:0]    r_d [3];
    logic signed [31:0]                 r_n [3];
    logic signed [lbvs_pkg::R_W-1:0]    r_c [3];
    logic signed [lbvs_pkg::R_W-1:0]    r_e [3];
    logic signed [lbvs_pkg::R_W-1:0]    r_g [3];
    logic signed [lbvs_pkg::P_W-1:0]    r_p [3];
    logic signed [lbvs_pkg::PROD_W-1:0] r_prod;
    logic signed [lbvs_pkg::WP_W-1:0]   r_wprod;

    logic signed [63:0]             r_sum [3];
    logic [lbvs_pkg::WT_W-1:0]      r_wt_total;
    logic signed [31:0]             r_land [3];
    logic                           r_held;

    logic                r_out_valid;
    lbvs_pkg::t_out_item r_out;

    // ---------------- input decode ----------------
    logic          in_xfer;
    logic          bone_ok;
    logic [AW+7:0] base_full;
    logic [AW+7:0] wr_full;

    assign in_xfer   = i_in_valid && !o_in_stall;
    assign o_in_stall = r_state != S_IDLE;
    assign bone_ok   = {1'b0, i_in_data.bone} < 9'(BONES);
    assign base_full = ({{AW{1'b0}}, i_in_data.bone} << 3)
                     + ({{AW{1'b0}}, i_in_data.bone} << 1);
    assign wr_full   = base_full + {{(AW+4){1'b0}}, i_in_data.slot};

    // ---------------- bone memory ----------------
    logic          mem_wr_en;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic [31:0]   mem_rd_data;

    assign mem_wr_en   = in_xfer && (i_in_data.cmd == lbvs_pkg::CMD_WRITE) && bone_ok
                       && (i_in_data.slot <= lbvs_pkg::SLOT_LAST);
    assign mem_rd_en   = (r_state == S_READ) && (r_cnt < 5'd10);
    assign mem_rd_addr = r_base + AW'(r_cnt);

    lbvs_bone_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (wr_full[AW-1:0]),
        .i_wr_data (i_in_data.word_value),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // read data is registered and belongs to the slot issued before it
    logic [3:0]         cap_slot;
    logic signed [31:0] rd_s;
    logic signed [lbvs_pkg::Q_W-1:0] q_sat;

    assign cap_slot = r_cnt[3:0] - 4'd1;
    assign rd_s     = mem_rd_data;
    always_comb begin
        if (rd_s > 32'sh4000_0000) begin
            q_sat = Q_POS;
        end else if (rd_s < -32'sh4000_0000) begin
            q_sat = Q_NEG;
        end else begin
            q_sat = rd_s[lbvs_pkg::Q_W-1:0];
        end
    end

    // ---------------- shared product unit ----------------
    lbvs_pkg::t_op                      op;
    logic signed [lbvs_pkg::B_W-1:0]    b_sel;
    logic signed [lbvs_pkg::PROD_W-1:0] prod_rnd;
    logic signed [lbvs_pkg::R_W-1:0]    rnd;
    logic signed [lbvs_pkg::R_W-1:0]    term;

    assign op = lbvs_pkg::op_entry(r_cnt);

    always_comb begin
        case (op.bi)
            3'd0:    b_sel = lbvs_pkg::B_W'(r_d[0]);
            3'd1:    b_sel = lbvs_pkg::B_W'(r_d[1]);
            3'd2:    b_sel = lbvs_pkg::B_W'(r_d[2]);
            3'd3:    b_sel = r_c[0][lbvs_pkg::B_W-1:0];
            3'd4:    b_sel = r_c[1][lbvs_pkg::B_W-1:0];
            3'd5:    b_sel = r_c[2][lbvs_pkg::B_W-1:0];
            default: b_sel = '0;
        endcase
    end

    // round to nearest, ties up: floor((p + 2^29) / 2^30)
    assign prod_rnd = r_prod + (lbvs_pkg::PROD_W'(1) <<< 29);
    assign rnd      = lbvs_pkg::R_W'(prod_rnd >>> 30);
    assign term     = op.neg ? -rnd : rnd;

    // ---------------- weighted sum ----------------
    logic signed [64:0] sum_ext;
    logic signed [63:0] sum_sat;
    logic [lbvs_pkg::WT_W:0] wt_next;

    assign sum_ext = {r_sum[r_cnt[1:0]][63], r_sum[r_cnt[1:0]]}
                   + 65'(r_wprod);
    always_comb begin
        if (sum_ext[64] != sum_ext[63]) begin
            sum_sat = sum_ext[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            sum_sat = sum_ext[63:0];
        end
    end
    assign wt_next = {1'b0, r_wt_total} + (lbvs_pkg::WT_W+1)'(r_weight);

    // ---------------- divide ----------------
    logic        div_start;
    logic        div_busy;
    logic        div_done;
    logic [63:0] div_quo;
    logic        s_neg;
    logic [63:0] s_mag;
    logic [63:0] div_num;
    logic signed [31:0] land_sat;

    assign s_neg     = r_sum[r_cnt[1:0]][63];
    assign s_mag     = s_neg ? (64'd0 - r_sum[r_cnt[1:0]]) : r_sum[r_cnt[1:0]];
    assign div_num   = s_mag + 64'(r_wt_total >> 1);
    assign div_start = (r_state == S_FIN) && (r_wt_total != '0);

    lbvs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_wt_total),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        if (s_neg) begin
            land_sat = (div_quo > 64'h8000_0000) ? 32'sh8000_0000
                                                 : 32'(64'd0 - div_quo);
        end else begin
            land_sat = (div_quo > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(div_quo);
        end
    end

    logic out_free;
    assign out_free = !r_out_valid || !i_out_stall;

    // ---------------- sequencer ----------------
    logic [3:0] n_state;
    logic [4:0] n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (in_xfer && (i_in_data.cmd == lbvs_pkg::CMD_INFLUENCE)) begin
                    if (bone_ok && (i_in_data.weight != '0)) begin
                        n_state = S_READ;
                    end else if (i_in_data.last_influence) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_READ: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd10) begin
                    n_state = S_MUL;
                    n_cnt   = '0;
                end
            end
            S_MUL: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                n_cnt   = r_cnt + 5'd1;
                n_state = S_MUL;
                if (r_cnt == 5'(lbvs_pkg::N_OPS - 1)) begin
                    n_state = S_PSUM;
                    n_cnt   = '0;
                end
            end
            S_PSUM: begin
                n_state = S_WMUL;
            end
            S_WMUL: begin
                n_state = S_SACC;
            end
            S_SACC: begin
                n_cnt   = r_cnt + 5'd1;
                n_state = S_WMUL;
                if (r_cnt == 5'd2) begin
                    n_cnt   = '0;
                    n_state = r_last ? S_FIN : S_IDLE;
                end
            end
            S_FIN: begin
                n_state = (r_wt_total == '0) ? S_EMIT : S_DWAIT;
            end
            S_DWAIT: begin
                if (div_done) begin
                    n_cnt   = r_cnt + 5'd1;
                    n_state = S_FIN;
                    if (r_cnt == 5'd2) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_wt_total  <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_sum[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;

            if (r_state == S_SACC) begin
                r_sum[r_cnt[1:0]] <= sum_sat;
                if (r_cnt == 5'd2) begin
                    r_wt_total <= wt_next[lbvs_pkg::WT_W] ? lbvs_pkg::WT_MAX
                                                          : wt_next[lbvs_pkg::WT_W-1:0];
                end
            end

            if ((r_state == S_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
                r_wt_total  <= '0;
                for (int k = 0; k < 3; k++) begin
                    r_sum[k] <= '0;
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_base   <= base_full[AW-1:0];
                r_weight <= i_in_data.weight;
                r_last   <= i_in_data.last_influence;
                r_pos[0] <= i_in_data.pos_x;
                r_pos[1] <= i_in_data.pos_y;
                r_pos[2] <= i_in_data.pos_z;
                for (int k = 0; k < 3; k++) begin
                    r_c[k] <= '0;
                    r_e[k] <= '0;
                    r_g[k] <= '0;
                end
            end
            S_READ: begin
                if (r_cnt != 5'd0) begin
                    case (cap_slot)
                        4'd0: r_u[0] <= q_sat;
                        4'd1: r_u[1] <= q_sat;
                        4'd2: r_u[2] <= q_sat;
                        4'd3: r_u[3] <= q_sat;
                        4'd4: r_d[0] <= 33'(r_pos[0]) - 33'(rd_s);
                        4'd5: r_d[1] <= 33'(r_pos[1]) - 33'(rd_s);
                        4'd6: r_d[2] <= 33'(r_pos[2]) - 33'(rd_s);
                        4'd7: r_n[0] <= rd_s;
                        4'd8: r_n[1] <= rd_s;
                        4'd9: r_n[2] <= rd_s;
                        default: ;
                    endcase
                end
            end
            S_MUL: begin
                r_prod <= lbvs_pkg::PROD_W'(r_u[op.ai]) * lbvs_pkg::PROD_W'(b_sel);
            end
            S_ACC: begin
                case (op.grp)
                    lbvs_pkg::GRP_C: r_c[op.tidx] <= r_c[op.tidx] + term;
                    lbvs_pkg::GRP_E: r_e[op.tidx] <= r_e[op.tidx] + term;
                    lbvs_pkg::GRP_G: r_g[op.tidx] <= r_g[op.tidx] + term;
                    default: ;
                endcase
            end
            S_PSUM: begin
                for (int k = 0; k < 3; k++) begin
                    r_p[k] <= lbvs_pkg::P_W'(r_d[k]) + (lbvs_pkg::P_W'(r_g[k]) <<< 1)
                            + (lbvs_pkg::P_W'(r_e[k]) <<< 1) + lbvs_pkg::P_W'(r_n[k]);
                end
            end
            S_WMUL: begin
                r_wprod <= lbvs_pkg::WP_W'(r_p[r_cnt[1:0]])
                         * lbvs_pkg::WP_W'($signed({1'b0, r_weight}));
            end
            S_FIN: begin
                if (r_wt_total == '0) begin
                    r_held <= 1'b0;
                    for (int k = 0; k < 3; k++) begin
                        r_land[k] <= '0;
                    end
                end else begin
                    r_held <= 1'b1;
                end
            end
            S_DWAIT: begin
                if (div_done) begin
                    r_land[r_cnt[1:0]] <= land_sat;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    r_out.land_x <= r_land[0];
                    r_out.land_y <= r_land[1];
                    r_out.land_z <= r_land[2];
                    r_out.held   <= r_held;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !div_busy)
        else $error("divider busy while sequencer idle");

    a_write_keeps_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_in_data.cmd == lbvs_pkg::CMD_WRITE)) |=>
            ($stable(r_wt_total) && $stable(r_sum[0]) && (r_state == S_IDLE)))
        else $error("table write disturbed accumulators");

    a_read_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_cnt <= 5'd10))
        else $error("bone read counter overran");

    a_emit_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && (r_state == S_EMIT)) |=> (r_state == S_EMIT))
        else $error("result overwrote a held output");
`endif

endmodule
